>>> rtl/ppc_pkg.sv
package ppc_pkg;

  localparam int unsigned CoordBitsDefault = 32;
  localparam int unsigned FieldBits = 32;
  localparam int unsigned NormBits = 18;
  localparam int unsigned TolBits = 16;
  localparam int unsigned DistBits = 64;
  localparam int unsigned FracBits = 32;
  localparam logic [TolBits-1:0] TolReset = 16'd66;

  // Sequencer states.
  typedef enum logic [3:0] {
    StIdle,
    StDist,
    StEdgeSetup,
    StEmitA,
    StDivide,
    StRound,
    StLerp,
    StEmitX,
    StNextEdge,
    StEmitEnd
  } state_e;

  // Edge role: the edge from the previous vertex, or the closing edge.
  typedef enum logic {
    EdgePrev,
    EdgeClose
  } edge_e;

endpackage

>>> rtl/ppc_if.sv
interface ppc_vtx_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [ppc_pkg::FieldBits-1:0]    vertex_x;
  logic signed [ppc_pkg::FieldBits-1:0]    vertex_y;
  logic signed [ppc_pkg::FieldBits-1:0]    vertex_z;
  logic signed [ppc_pkg::NormBits-1:0]     normal_x;
  logic signed [ppc_pkg::NormBits-1:0]     normal_y;
  logic signed [ppc_pkg::NormBits-1:0]     normal_z;
  logic signed [ppc_pkg::FieldBits-1:0]    plane_offset;
  logic                                     last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y,
                  normal_z, plane_offset, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y,
                normal_z, plane_offset, last_vertex, output ready);
endinterface

interface ppc_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [ppc_pkg::FieldBits-1:0]    out_x;
  logic signed [ppc_pkg::FieldBits-1:0]    out_y;
  logic signed [ppc_pkg::FieldBits-1:0]    out_z;
  logic                                     vertex_present;
  logic                                     polygon_end;

  modport source (output valid, out_x, out_y, out_z, vertex_present, polygon_end,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, vertex_present, polygon_end,
                output ready);
endinterface

>>> rtl/polygon_plane_clipper.sv
// Clips a convex polygon against one plane (Sutherland-Hodgman), keeping the
// part whose signed distance is at most the configured tolerance (units of 2^-8).
// One vertex request is taken at a time; ready stays low while it is worked.
// The distance is summed axis by axis on one shared 34x34 multiply-accumulate
// step; each crossing edge adds a serial divider, a rounding step, the
// interpolation on the same multiplier and an emit step. A vertex that opens a
// polygon and is not its last only has its distance taken; a later vertex also
// clips the edge from the previous vertex, and a closing vertex clips the
// closing edge too. Each result item also waits for the output handshake, so a
// stalled receiver holds the block up.
// An empty polygon gives one item with vertex_present low and polygon_end
// high; a final vertex that emits nothing also closes with such an item.
module polygon_plane_clipper #(
  parameter int unsigned COORD_BITS = ppc_pkg::CoordBitsDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ppc_pkg::TolBits-1:0]      cfg_wdata_i,
  ppc_vtx_if.sink                          vtx,
  ppc_out_if.source                        res
);

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned DB = ppc_pkg::DistBits;
  localparam int unsigned MB = DB + 8;

  typedef logic signed [CB-1:0] coord_t;

  logic [ppc_pkg::TolBits-1:0] tol_q;
  ppc_pkg::state_e state_q, state_d;

  coord_t p_q [3];
  coord_t f_q [3];
  coord_t a_q [3];
  coord_t b_q [3];
  coord_t x_q [3];
  logic signed [ppc_pkg::NormBits-1:0] n_q [3];
  logic signed [ppc_pkg::FieldBits-1:0] off_q;
  logic signed [DB-1:0] d_q, fd_q, pd_q, da_q, db_q;
  logic signed [MB-1:0] acc_q;
  logic last_q, mid_q, k_q;
  ppc_pkg::edge_e edge_q;
  logic [1:0] ax_q;

  logic [DB-1:0] den_q, rem_q;
  logic [ppc_pkg::FracBits:0] t_q;
  logic [5:0] cnt_q;

  logic o_valid_q, o_pres_q, o_end_q;
  logic [ppc_pkg::FieldBits-1:0] o_x_q, o_y_q, o_z_q;

  // Extend an input coordinate field to the internal coordinate width.
  function automatic coord_t ext_coord(input logic [ppc_pkg::FieldBits-1:0] v);
    logic [CB+ppc_pkg::FieldBits-1:0] w;
    w = {{CB{1'b0}}, v};
    return coord_t'(w[CB-1:0]);
  endfunction

  function automatic logic [ppc_pkg::FieldBits-1:0] to_field(input coord_t v);
    logic signed [CB+ppc_pkg::FieldBits-1:0] w;
    w = (CB+ppc_pkg::FieldBits)'(v);
    return w[ppc_pkg::FieldBits-1:0];
  endfunction

  logic signed [DB-1:0] tol_s;
  assign tol_s = DB'($signed({1'b0, tol_q}));

  logic ina, inb;
  assign ina = (da_q <= tol_s);
  assign inb = (db_q <= tol_s);

  // The closing edge emits something when either of its ends is inside, so the
  // last item of the step is known before any of its items is sent.
  logic close_in, edge_last;
  assign close_in = (d_q <= tol_s) || (fd_q <= tol_s);
  assign edge_last = last_q && ((edge_q == ppc_pkg::EdgeClose) || !close_in);

  // Shared multiplier: normal times coordinate, or difference times t.
  logic signed [CB+1:0] mul_a;
  logic signed [ppc_pkg::FracBits+1:0] mul_b;
  logic signed [CB+ppc_pkg::FracBits+3:0] mul_p;
  always_comb begin
    if (state_q == ppc_pkg::StDist) begin
      mul_a = (CB+2)'(p_q[ax_q]);
      mul_b = (ppc_pkg::FracBits+2)'(n_q[ax_q]);
    end else begin
      mul_a = (CB+2)'(b_q[ax_q]) - (CB+2)'(a_q[ax_q]);
      mul_b = $signed({1'b0, t_q});
    end
    mul_p = (CB+ppc_pkg::FracBits+4)'(mul_a) * (CB+ppc_pkg::FracBits+4)'(mul_b);
  end

  // Lerp result: round magnitude half away from zero, then saturate.
  logic [CB+ppc_pkg::FracBits+3:0] mag;
  logic signed [CB+3:0] q_s, sum_s;
  coord_t lerp_v;
  localparam logic signed [CB+3:0] CMax = (CB+4)'((65'sd1 <<< (CB-1)) - 1);
  localparam logic signed [CB+3:0] CMin = -CMax - 1;
  always_comb begin
    mag = mul_p[CB+ppc_pkg::FracBits+3] ? (CB+ppc_pkg::FracBits+4)'(-mul_p)
                                         : (CB+ppc_pkg::FracBits+4)'(mul_p);
    q_s = $signed((CB+4)'((mag + ((CB+ppc_pkg::FracBits+4)'(1) << (ppc_pkg::FracBits-1)))
                          >> ppc_pkg::FracBits));
    if (mul_p[CB+ppc_pkg::FracBits+3]) begin
      sum_s = (CB+4)'(a_q[ax_q]) - q_s;
    end else begin
      sum_s = (CB+4)'(a_q[ax_q]) + q_s;
    end
    if (sum_s > CMax) begin
      lerp_v = coord_t'(CMax);
    end else if (sum_s < CMin) begin
      lerp_v = coord_t'(CMin);
    end else begin
      lerp_v = coord_t'(sum_s);
    end
  end

  // Divider step and distance floor.
  logic [DB:0] rem_sh;
  logic [DB:0] rem_sub;
  assign rem_sh = {rem_q, 1'b0};
  assign rem_sub = rem_sh - {1'b0, den_q};

  logic signed [MB-1:0] acc_fin;
  assign acc_fin = acc_q + (MB'(off_q) <<< 16);
  logic signed [DB-1:0] dist_v;
  assign dist_v = DB'(acc_fin >>> 8);

  logic signed [DB-1:0] num_s, den_s;
  always_comb begin
    den_s = da_q - db_q;
    num_s = da_q;
    if (den_s < 0) begin
      den_s = -den_s;
      num_s = -num_s;
    end
  end

  assign vtx.ready = (state_q == ppc_pkg::StIdle);
  assign res.valid = o_valid_q;
  assign res.out_x = o_x_q;
  assign res.out_y = o_y_q;
  assign res.out_z = o_z_q;
  assign res.vertex_present = o_pres_q;
  assign res.polygon_end = o_end_q;

  logic out_free;
  assign out_free = !o_valid_q || res.ready;

  // A new result item enters the output register in this cycle.
  logic out_load;
  assign out_load = ((state_q == ppc_pkg::StEmitA) && ina && out_free) ||
                    ((state_q == ppc_pkg::StEmitX) && out_free) ||
                    ((state_q == ppc_pkg::StEmitEnd) && !k_q && out_free);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ppc_pkg::StIdle: if (vtx.valid) state_d = ppc_pkg::StDist;
      ppc_pkg::StDist: if (ax_q == 2'd3) state_d =
          mid_q ? ppc_pkg::StEdgeSetup : ppc_pkg::StNextEdge;
      ppc_pkg::StEdgeSetup: state_d = ppc_pkg::StEmitA;
      ppc_pkg::StEmitA: if (!ina || out_free) state_d =
          (ina != inb) ? ppc_pkg::StDivide : ppc_pkg::StNextEdge;
      ppc_pkg::StDivide: if (cnt_q == 6'd32) state_d = ppc_pkg::StRound;
      ppc_pkg::StRound: state_d = ppc_pkg::StLerp;
      ppc_pkg::StLerp: if (ax_q == 2'd2) state_d = ppc_pkg::StEmitX;
      ppc_pkg::StEmitX: if (out_free) state_d = ppc_pkg::StNextEdge;
      ppc_pkg::StNextEdge: begin
        if (edge_q == ppc_pkg::EdgePrev) begin
          state_d = last_q ? ppc_pkg::StEdgeSetup : ppc_pkg::StIdle;
        end else begin
          state_d = ppc_pkg::StEmitEnd;
        end
      end
      ppc_pkg::StEmitEnd: if (k_q || out_free) state_d = ppc_pkg::StIdle;
      default: state_d = ppc_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ppc_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= ppc_pkg::TolReset;
      mid_q <= 1'b0;
      o_valid_q <= 1'b0;
      o_pres_q <= 1'b0;
      o_end_q <= 1'b0;
      o_x_q <= '0;
      o_y_q <= '0;
      o_z_q <= '0;
      fd_q <= '0;
      pd_q <= '0;
      for (int i = 0; i < 3; i++) begin
        f_q[i] <= '0;
        a_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) tol_q <= cfg_wdata_i;
      if (out_load) begin
        o_valid_q <= 1'b1;
      end else if (res.ready) begin
        o_valid_q <= 1'b0;
      end
      case (state_q)
        ppc_pkg::StDist: if (ax_q == 2'd3 && !mid_q) begin
          f_q <= p_q;
          fd_q <= dist_v;
        end
        ppc_pkg::StEmitA: if (ina && out_free) begin
          o_x_q <= to_field(a_q[0]);
          o_y_q <= to_field(a_q[1]);
          o_z_q <= to_field(a_q[2]);
          o_pres_q <= 1'b1;
          o_end_q <= edge_last && (ina == inb);
        end
        ppc_pkg::StEmitX: if (out_free) begin
          o_x_q <= to_field(x_q[0]);
          o_y_q <= to_field(x_q[1]);
          o_z_q <= to_field(x_q[2]);
          o_pres_q <= 1'b1;
          o_end_q <= edge_last;
        end
        ppc_pkg::StNextEdge: if (edge_q == ppc_pkg::EdgePrev) begin
          // The current vertex becomes the previous one.
          pd_q <= d_q;
          a_q <= p_q;
          if (!last_q) mid_q <= 1'b1;
        end
        ppc_pkg::StEmitEnd: begin
          mid_q <= 1'b0;
          if (!k_q && out_free) begin
            o_x_q <= '0;
            o_y_q <= '0;
            o_z_q <= '0;
            o_pres_q <= 1'b0;
            o_end_q <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ppc_pkg::StIdle: if (vtx.valid) begin
        p_q[0] <= ext_coord(vtx.vertex_x);
        p_q[1] <= ext_coord(vtx.vertex_y);
        p_q[2] <= ext_coord(vtx.vertex_z);
        n_q[0] <= vtx.normal_x;
        n_q[1] <= vtx.normal_y;
        n_q[2] <= vtx.normal_z;
        off_q <= vtx.plane_offset;
        last_q <= vtx.last_vertex;
        acc_q <= '0;
        ax_q <= '0;
      end
      ppc_pkg::StDist: begin
        if (ax_q == 2'd3) begin
          d_q <= dist_v;
          edge_q <= ppc_pkg::EdgePrev;
          k_q <= 1'b0;
        end else begin
          acc_q <= acc_q + MB'(mul_p);
          ax_q <= ax_q + 2'd1;
        end
      end
      ppc_pkg::StEdgeSetup: begin
        if (edge_q == ppc_pkg::EdgePrev) begin
          b_q <= p_q;
          da_q <= pd_q;
          db_q <= d_q;
        end else begin
          b_q <= f_q;
          da_q <= d_q;
          db_q <= fd_q;
        end
      end
      ppc_pkg::StEmitA: if (!ina || out_free) begin
        if (ina) k_q <= 1'b1;
        den_q <= DB'(den_s);
        rem_q <= DB'(num_s);
        t_q <= '0;
        cnt_q <= '0;
      end
      ppc_pkg::StDivide: begin
        if (cnt_q == 6'd0 && (den_q == '0 || $signed(rem_q) <= 0)) begin
          t_q <= '0;
          cnt_q <= 6'd32;
        end else if (cnt_q == 6'd0 && rem_q >= den_q) begin
          t_q <= (ppc_pkg::FracBits+1)'(1) << ppc_pkg::FracBits;
          cnt_q <= 6'd32;
          rem_q <= '0;
          den_q <= DB'(1);
        end else if (cnt_q != 6'd32) begin
          if (rem_sh >= {1'b0, den_q}) begin
            rem_q <= rem_sub[DB-1:0];
            t_q <= {t_q[ppc_pkg::FracBits-1:0], 1'b1};
          end else begin
            rem_q <= rem_sh[DB-1:0];
            t_q <= {t_q[ppc_pkg::FracBits-1:0], 1'b0};
          end
          cnt_q <= cnt_q + 6'd1;
        end
      end
      ppc_pkg::StRound: begin
        if (den_q != '0 && t_q[ppc_pkg::FracBits] == 1'b0 &&
            {rem_q, 1'b0} >= {1'b0, den_q} && $signed(rem_q) > 0)
          t_q <= t_q + (ppc_pkg::FracBits+1)'(1);
        ax_q <= '0;
      end
      ppc_pkg::StLerp: begin
        x_q[ax_q] <= lerp_v;
        ax_q <= ax_q + 2'd1;
      end
      ppc_pkg::StEmitX: if (out_free) k_q <= 1'b1;
      ppc_pkg::StNextEdge: begin
        if (edge_q == ppc_pkg::EdgePrev && last_q) begin
          edge_q <= ppc_pkg::EdgeClose;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> tb/sv/clip_result_checker.sv
`timescale 1ns / 1ps

module clip_result_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ppc_pkg::TolBits-1:0] cfg_wdata_i,
  ppc_vtx_if                          vtx,
  ppc_out_if                          res,
  output int                          errors_o,
  output int                          pending_o
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        present;
    logic        pend;
  } clip_vertex_t;

  clip_vertex_t expected_clip_q[$];

  // Predicted block state.
  logic [ppc_pkg::TolBits-1:0] tolerance;
  longint first_pt[3];
  longint first_dist;
  longint prev_pt[3];
  longint prev_dist;
  bit     mid_poly;

  // Signed distance in Q56.8, floored.
  function automatic longint plane_distance(input longint p[3], input longint n[3],
                                            input longint off);
    longint s;
    s = n[0] * p[0] + n[1] * p[1] + n[2] * p[2] + off * 65536;
    return s >>> 8;
  endfunction

  // Edge fraction t in Q1.32, clamped to [0, 1] and rounded half up.
  function automatic longint unsigned crossing_fraction(input longint da, input longint db);
    longint den;
    longint num;
    logic [63:0] r;
    logic [63:0] d;
    longint unsigned t;
    int i;
    den = da - db;
    num = da;
    if (den < 0) begin
      den = -den;
      num = -num;
    end
    if (den == 0 || num <= 0) return 0;
    if (num >= den) return 64'd1 << 32;
    r = num;
    d = den;
    t = 0;
    for (i = 0; i < 32; i++) begin
      r = r << 1;
      t = t << 1;
      if (r >= d) begin
        r = r - d;
        t = t | 1;
      end
    end
    if (2 * r >= d) t++;
    return t;
  endfunction

  // One interpolated axis, magnitude rounded half away from zero, saturated.
  function automatic longint lerp_axis(input longint a, input longint b,
                                       input longint unsigned t);
    longint diff;
    longint mag;
    longint q;
    longint v;
    logic [127:0] prod;
    diff = b - a;
    mag = (diff < 0) ? -diff : diff;
    prod = 128'(mag) * 128'(t) + (128'd1 << 31);
    q = longint'(prod[95:32]);
    v = (diff < 0) ? a - q : a + q;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic void push_vertex(input longint p[3], input bit present);
    clip_vertex_t e;
    e.x = present ? p[0][31:0] : '0;
    e.y = present ? p[1][31:0] : '0;
    e.z = present ? p[2][31:0] : '0;
    e.present = present;
    e.pend = 1'b0;
    expected_clip_q.insert(expected_clip_q.size(), e);
  endfunction

  // Start vertex if inside, then the crossing if the edge crosses.
  function automatic int clip_edge(input longint a[3], input longint da,
                                   input longint b[3], input longint db);
    bit ina;
    bit inb;
    int k;
    longint unsigned t;
    longint x[3];
    ina = da <= longint'(tolerance);
    inb = db <= longint'(tolerance);
    k = 0;
    if (ina) begin
      push_vertex(a, 1'b1);
      k++;
    end
    if (ina != inb) begin
      t = crossing_fraction(da, db);
      for (int j = 0; j < 3; j++) x[j] = lerp_axis(a[j], b[j], t);
      push_vertex(x, 1'b1);
      k++;
    end
    return k;
  endfunction

  function automatic void predict_vertex();
    longint p[3];
    longint n[3];
    longint off;
    longint d;
    int k;
    p[0] = $signed(vtx.vertex_x);
    p[1] = $signed(vtx.vertex_y);
    p[2] = $signed(vtx.vertex_z);
    n[0] = $signed(vtx.normal_x);
    n[1] = $signed(vtx.normal_y);
    n[2] = $signed(vtx.normal_z);
    off = $signed(vtx.plane_offset);
    d = plane_distance(p, n, off);
    k = 0;
    if (mid_poly) begin
      k = clip_edge(prev_pt, prev_dist, p, d);
    end else begin
      first_pt = p;
      first_dist = d;
    end
    prev_pt = p;
    prev_dist = d;
    if (vtx.last_vertex) begin
      k += clip_edge(p, d, first_pt, first_dist);
      if (k == 0) push_vertex(p, 1'b0);
      expected_clip_q[expected_clip_q.size() - 1].pend = 1'b1;
      mid_poly = 1'b0;
    end else begin
      mid_poly = 1'b1;
    end
  endfunction

  function automatic void check_result();
    clip_vertex_t e;
    if (expected_clip_q.size() == 0) begin
      $display("%0t: unexpected result x=%h y=%h z=%h present=%b end=%b", $time,
               res.out_x, res.out_y, res.out_z, res.vertex_present, res.polygon_end);
      errors_o++;
      return;
    end
    e = expected_clip_q.pop_front();
    if (res.out_x !== e.x || res.out_y !== e.y || res.out_z !== e.z ||
        res.vertex_present !== e.present || res.polygon_end !== e.pend) begin
      $display("%0t: mismatch expected x=%h y=%h z=%h present=%b end=%b", $time,
               e.x, e.y, e.z, e.present, e.pend);
      $display("%0t:          actual   x=%h y=%h z=%h present=%b end=%b", $time,
               res.out_x, res.out_y, res.out_z, res.vertex_present, res.polygon_end);
      errors_o++;
    end
  endfunction

  // Track configuration, accepted requests and accepted results.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance <= ppc_pkg::TolReset;
      first_pt = '{0, 0, 0};
      prev_pt = '{0, 0, 0};
      first_dist = 0;
      prev_dist = 0;
      mid_poly = 1'b0;
      expected_clip_q.delete();
      errors_o = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) tolerance <= cfg_wdata_i;
      if (res.valid && res.ready) check_result();
      if (vtx.valid && vtx.ready) predict_vertex();
      pending_o <= expected_clip_q.size();
    end
  end

endmodule

>>> tb/sv/polygon_plane_clipper_test.sv
`timescale 1ns / 1ps

module polygon_plane_clipper_test;

  localparam int StallLimit = 5000;
  localparam int HoldCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [ppc_pkg::TolBits-1:0] cfg_wdata_i = '0;
  int errors;
  int pending;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int stalled_cycles = 0;
  int sent = 0;

  // Plane sent with each vertex of the polygon; it may change mid-polygon.
  logic [17:0] pnx;
  logic [17:0] pny;
  logic [17:0] pnz;
  logic [31:0] poff;

  ppc_vtx_if vtx ();
  ppc_out_if res ();

  polygon_plane_clipper dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .vtx        (vtx),
    .res        (res)
  );

  clip_result_checker checker_i (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .vtx        (vtx),
    .res        (res),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off when asked.
  always @(posedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      res.ready <= 1'b0;
    end else begin
      res.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on cycles with no handshake at all.
  always @(posedge clk_i) begin
    if ((vtx.valid && vtx.ready) || (res.valid && res.ready)) begin
      stalled_cycles <= 0;
    end else if (rst_ni) begin
      stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles == StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_vertex(input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      vtx.valid <= 1'b0;
      @(posedge clk_i);
    end
    vtx.valid <= 1'b1;
    vtx.vertex_x <= x;
    vtx.vertex_y <= y;
    vtx.vertex_z <= z;
    vtx.normal_x <= pnx;
    vtx.normal_y <= pny;
    vtx.normal_z <= pnz;
    vtx.plane_offset <= poff;
    vtx.last_vertex <= last;
    @(posedge clk_i);
    while (!vtx.ready) @(posedge clk_i);
    sent++;
  endtask

  // Stop offering and wait until the block has drained.
  task automatic drain();
    vtx.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic set_tolerance(input logic [15:0] tol);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= tol;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_plane_x();
    pnx = 18'sd65536;
    pny = '0;
    pnz = '0;
    poff = '0;
  endtask

  function automatic logic [31:0] near_coord();
    return 32'($signed($urandom_range(0, 2 ** 21)) - 2 ** 20);
  endfunction

  task automatic random_plane(input bit wide);
    pnx = 18'($urandom);
    pny = 18'($urandom);
    pnz = 18'($urandom);
    poff = wide ? $urandom : near_coord();
  endtask

  // A polygon with random content; the plane may change mid-polygon.
  task automatic random_polygon(input bit wide);
    int n;
    n = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 6);
    random_plane(wide);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) random_plane(wide);
      if (wide) send_vertex($urandom, $urandom, $urandom, i == n - 1);
      else send_vertex(near_coord(), near_coord(), near_coord(), i == n - 1);
    end
  endtask

  task automatic random_phase(input int items);
    int stop_at;
    stop_at = sent + items;
    while (sent < stop_at) random_polygon($urandom_range(99) < 30);
  endtask

  initial begin
    vtx.valid = 1'b0;
    vtx.vertex_x = '0;
    vtx.vertex_y = '0;
    vtx.vertex_z = '0;
    vtx.normal_x = '0;
    vtx.normal_y = '0;
    vtx.normal_z = '0;
    vtx.plane_offset = '0;
    vtx.last_vertex = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single vertex inside, then single vertex outside (marker only).
    set_plane_x();
    send_vertex(32'd0, 32'd0, 32'd0, 1'b1);
    send_vertex(32'd256, 32'd5, 32'd7, 1'b1);
    // Triangle crossing the plane twice.
    send_vertex(-32'sd512, 32'd0, 32'd0, 1'b0);
    send_vertex(32'd512, 32'd100, 32'd0, 1'b0);
    send_vertex(32'd0, 32'd512, -32'sd300, 1'b1);
    // Fully outside polygon.
    send_vertex(32'd1000, 32'd0, 32'd0, 1'b0);
    send_vertex(32'd2000, 32'd0, 32'd0, 1'b1);
    // Last step emits nothing, so a closing marker follows.
    send_vertex(32'd512, 32'd0, 32'd0, 1'b0);
    send_vertex(-32'sd512, 32'd64, 32'd0, 1'b0);
    send_vertex(32'd512, 32'd128, 32'd0, 1'b0);
    send_vertex(32'd512, 32'd0, 32'd9, 1'b1);
    // Plane flips direction mid-polygon.
    send_vertex(-32'sd700, 32'd3, 32'd0, 1'b0);
    pnx = -18'sd65536;
    send_vertex(-32'sd300, 32'd0, 32'd1, 1'b0);
    send_vertex(32'd400, 32'd0, 32'd0, 1'b1);
    // Extreme fields, saturating interpolation.
    pnx = 18'sd131071;
    pny = -18'sd131072;
    pnz = 18'sd131071;
    poff = 32'h8000_0000;
    send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0);
    poff = 32'h7fff_ffff;
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_vertex(32'hffff_ffff, 32'h0, 32'h8000_0000, 1'b1);
    // Tolerance band: crossings whose fraction clamps to 0 and to 1.
    set_tolerance(16'hffff);
    set_plane_x();
    send_vertex(32'd1, 32'd0, 32'd0, 1'b0);
    send_vertex(32'd300, 32'd50, 32'd0, 1'b0);
    send_vertex(32'd2, 32'd0, 32'd50, 1'b1);

    // Long hold-off on results while requests keep coming.
    drain();
    hold_req = hold_req + 1;
    random_polygon(1'b0);
    random_polygon(1'b0);

    set_tolerance(16'd0);
    random_phase(50);
    idle_pct = 64;
    set_tolerance(16'hffff);
    random_phase(50);
    idle_pct = 0;
    stall_pct = 64;
    set_tolerance(16'($urandom));
    random_phase(50);
    idle_pct = 28;
    stall_pct = 28;
    set_tolerance(ppc_pkg::TolReset);
    random_phase(50);

    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/ppc_pkg.sv
rtl/ppc_if.sv
rtl/polygon_plane_clipper.sv
tb/sv/clip_result_checker.sv
tb/sv/polygon_plane_clipper_test.sv
